// ----- sv/ffha_pkg.sv -----
// Shared types, codes and constants of the first-fit heap allocator.
// No dependencies; the allocator, fit unit, checker and testbench import this package.
`default_nettype none

package ffha_pkg;

   localparam int DEFAULT_HEAP_WORDS       = 128;
   localparam int DEFAULT_INIT_BLOCK_WORDS = 10;
   localparam int INIT_SMALL_BLOCKS        = 5;
   localparam int WORD_BYTES               = 8;
   localparam int PAYLOAD_MAX              = 1023;
   // highest header word whose payload offset still fits the result field
   localparam int MAX_HDR_POS              = (PAYLOAD_MAX - WORD_BYTES) / WORD_BYTES;

   localparam int OFFW    = 10;   // byte offsets and request sizes
   localparam int NEED_W  = 8;    // block size in words, header included
   localparam int FLAG_W  = 3;    // low header bits below the size

   localparam logic [FLAG_W-1:0] TAKEN_FLAGS = 3'b001;

   typedef enum logic {
      OP_ALLOC,
      OP_RELEASE
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_FIT,
      STATUS_MISALIGNED
   } status_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [OFFW-1:0]   request_bytes;
      logic [OFFW-1:0]   release_offset;
   } req_type;

   typedef struct packed {
      logic [OFFW-1:0]   payload_offset;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic split_enable;
   } csr_type;

   // verdict of the fit unit on one block header
   typedef struct packed {
      logic empty_hdr;
      logic fits;
      logic do_split;
      logic walk_done;
   } fit_flags_type;

endpackage

`default_nettype wire

// ----- sv/ffha_chan_if.sv -----
// Valid/ready channel used for the request, response and CSR ports.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface ffha_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/first_fit_heap_allocator.sv -----
// First-fit heap allocator over a header store of HEAP_WORDS 8-byte words.
// Channels: req_chan takes allocate (opcode 0, request_bytes) and release
// (opcode 1, release_offset) items; rsp_chan returns one payload_offset and
// status per item; csr_chan writes split_enable at any transfer.
// After reset the block sweeps the header store once, writing the initial
// free-block layout one word per cycle, so req_chan.ready stays low until
// the sweep ends. CSR transfers are taken during the sweep as ever.
// One item at a time: an allocate goes from its transfer through S_RD and
// one S_EVAL per header visited on the walk (one RAM read per header),
// then S_SPLIT when a free block is split, then S_RESP, which loads the
// response register. A release goes through S_REL_RD, then S_REL_WR when a
// header is read and rewritten, then S_RESP. The next request is taken in
// the cycle after the response register loads.
// The response sits in an output register; the next request is accepted
// while it waits. When the receiver stalls, a finished response holds the
// block in its last state until the register frees up.
// Depends on ffha_pkg, ffha_chan_if, ffha_ram and ffha_fit_unit.
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int HEAP_WORDS       = DEFAULT_HEAP_WORDS,
   parameter int INIT_BLOCK_WORDS = DEFAULT_INIT_BLOCK_WORDS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ffha_chan_if.sink    req_chan,
   ffha_chan_if.source  rsp_chan,
   ffha_chan_if.sink    csr_chan
);

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int PW = AW + 1;
   localparam int HW = PW + FLAG_W;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_RD,
      S_EVAL,
      S_SPLIT,
      S_REL_RD,
      S_REL_WR,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [OFFW-1:0]  offset_ff, offset_in;
   logic [HW-1:0]    rest_hdr_ff, rest_hdr_in;
   logic [AW-1:0]    rest_addr_ff, rest_addr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             split_en_ff, split_en_in;
   logic [PW-1:0]    init_blk_ff, init_blk_in;
   logic [2:0]       init_cnt_ff, init_cnt_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [HW-1:0]    ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [HW-1:0]    ram_rdata;

   fit_flags_type    fit;
   logic [AW-1:0]    fit_next_pos;
   logic [HW-1:0]    fit_take_hdr;
   logic [HW-1:0]    fit_rest_hdr;
   logic [AW-1:0]    fit_rest_addr;
   logic [OFFW-1:0]  fit_payload_off;

   logic             init_small;
   logic             init_rest;
   logic [OFFW:0]    req_sum;
   logic [OFFW-4:0]  rel_word;
   logic [AW-1:0]    rel_addr;
   logic             rel_misalign;
   logic             rel_in_heap;

   ffha_ram #(
      .WIDTH (HW),
      .DEPTH (HEAP_WORDS)
   ) u_hdr_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ffha_fit_unit #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_fit (
      .hdr         (ram_rdata),
      .pos         (pos_ff),
      .need        (need_ff),
      .split_en    (split_en_ff),
      .flags       (fit),
      .next_pos    (fit_next_pos),
      .take_hdr    (fit_take_hdr),
      .rest_hdr    (fit_rest_hdr),
      .rest_addr   (fit_rest_addr),
      .payload_off (fit_payload_off)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      init_small = (pos_ff == init_blk_ff) &&
                   (32'(init_cnt_ff) < INIT_SMALL_BLOCKS) &&
                   (32'(init_blk_ff) + INIT_BLOCK_WORDS <= HEAP_WORDS);
      init_rest  = (pos_ff == init_blk_ff) && !init_small;

      req_sum      = {1'b0, req_chan.payload.request_bytes} + (OFFW+1)'(7);
      rel_word     = offset_ff[OFFW-1:FLAG_W] - (OFFW-3)'(1);
      rel_addr     = AW'(rel_word);
      rel_misalign = (offset_ff[FLAG_W-1:0] != '0);
      rel_in_heap  = (offset_ff[OFFW-1:FLAG_W] != '0) && (32'(rel_word) < HEAP_WORDS);
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      need_in      = need_ff;
      offset_in    = offset_ff;
      rest_hdr_in  = rest_hdr_ff;
      rest_addr_in = rest_addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      split_en_in  = split_en_ff;
      init_blk_in  = init_blk_ff;
      init_cnt_in  = init_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff[AW-1:0];
      ram_wdata    = '0;
      ram_raddr    = pos_ff[AW-1:0];

      if (csr_chan.valid) begin
         split_en_in = csr_chan.payload.split_enable;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            if (init_small) begin
               ram_wdata   = HW'(INIT_BLOCK_WORDS * WORD_BYTES);
               init_blk_in = init_blk_ff + PW'(INIT_BLOCK_WORDS);
               init_cnt_in = init_cnt_ff + 3'd1;
            end else if (init_rest) begin
               ram_wdata = {PW'(HEAP_WORDS) - pos_ff, {FLAG_W{1'b0}}};
            end
            if (pos_ff == PW'(HEAP_WORDS - 1)) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.payload.opcode == OP_ALLOC) begin
                  need_in  = req_sum[OFFW:FLAG_W] + NEED_W'(1);
                  pos_in   = '0;
                  state_in = S_RD;
               end else begin
                  offset_in = req_chan.payload.release_offset;
                  state_in  = S_REL_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (fit.empty_hdr) begin
               res_in   = '{payload_offset: '0, status: STATUS_NO_FIT};
               state_in = S_RESP;
            end else if (fit.fits) begin
               ram_we       = 1'b1;
               ram_wdata    = fit_take_hdr;
               rest_hdr_in  = fit_rest_hdr;
               rest_addr_in = fit_rest_addr;
               res_in       = '{payload_offset: fit_payload_off, status: STATUS_OK};
               state_in     = fit.do_split ? S_SPLIT : S_RESP;
            end else if (fit.walk_done) begin
               res_in   = '{payload_offset: '0, status: STATUS_NO_FIT};
               state_in = S_RESP;
            end else begin
               // advance to the next header and read it right away
               pos_in    = PW'(fit_next_pos);
               ram_raddr = fit_next_pos;
            end
         end
         S_SPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = rest_addr_ff;
            ram_wdata = rest_hdr_ff;
            state_in  = S_RESP;
         end
         S_REL_RD: begin
            if (rel_misalign) begin
               res_in   = '{payload_offset: '0, status: STATUS_MISALIGNED};
               state_in = S_RESP;
            end else if (!rel_in_heap) begin
               res_in   = '{payload_offset: '0, status: STATUS_OK};
               state_in = S_RESP;
            end else begin
               ram_raddr = rel_addr;
               state_in  = S_REL_WR;
            end
         end
         S_REL_WR: begin
            ram_we    = 1'b1;
            ram_waddr = rel_addr;
            ram_wdata = {ram_rdata[HW-1:FLAG_W], {FLAG_W{1'b0}}};
            res_in    = '{payload_offset: '0, status: STATUS_OK};
            state_in  = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pos_ff       <= '0;
         init_blk_ff  <= '0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         split_en_ff  <= 1'b1;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         init_blk_ff  <= init_blk_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         split_en_ff  <= split_en_in;
      end
      need_ff      <= need_in;
      offset_ff    <= offset_in;
      rest_hdr_ff  <= rest_hdr_in;
      rest_addr_ff <= rest_addr_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- sv/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/ffha_fit_unit.sv -----
// Header evaluation unit: decides whether one block fits an allocate and
// forms the next walk position and the new headers. Depends on ffha_pkg.
`default_nettype none

module ffha_fit_unit import ffha_pkg::*; #(
   parameter int HEAP_WORDS = DEFAULT_HEAP_WORDS
) (
   input  wire logic [$clog2(HEAP_WORDS)+3:0] hdr,
   input  wire logic [$clog2(HEAP_WORDS):0]   pos,
   input  wire logic [NEED_W-1:0]             need,
   input  wire logic                          split_en,
   output      fit_flags_type                 flags,
   output      logic [$clog2(HEAP_WORDS)-1:0] next_pos,
   output      logic [$clog2(HEAP_WORDS)+3:0] take_hdr,
   output      logic [$clog2(HEAP_WORDS)+3:0] rest_hdr,
   output      logic [$clog2(HEAP_WORDS)-1:0] rest_addr,
   output      logic [OFFW-1:0]               payload_off
);

   localparam int AW   = $clog2(HEAP_WORDS);
   localparam int PW   = AW + 1;
   localparam int HW   = PW + FLAG_W;
   localparam int CMPW = (PW > NEED_W) ? PW : NEED_W;
   localparam int SUMW = CMPW + 1;

   logic [PW-1:0]   size;
   logic [CMPW-1:0] size_c;
   logic [CMPW-1:0] need_c;
   logic [CMPW-1:0] rest_words;
   logic [SUMW-1:0] next_sum;
   logic [SUMW-1:0] rest_sum;
   logic            free;

   always_comb begin
      size       = hdr[HW-1:FLAG_W];
      free       = (hdr[FLAG_W-1:0] == '0);
      size_c     = CMPW'(size);
      need_c     = CMPW'(need);
      rest_words = size_c - need_c;
      next_sum   = SUMW'(pos) + SUMW'(size);
      rest_sum   = SUMW'(pos) + SUMW'(need);

      flags.empty_hdr = (size == '0);
      flags.fits      = (size != '0) && free && (size_c >= need_c) &&
                        (32'(pos) <= MAX_HDR_POS);
      flags.do_split  = split_en && (size_c > need_c);
      flags.walk_done = (next_sum >= SUMW'(HEAP_WORDS));

      next_pos    = AW'(next_sum);
      take_hdr    = flags.do_split ? HW'({need, TAKEN_FLAGS}) : {size, TAKEN_FLAGS};
      rest_hdr    = HW'({rest_words, {FLAG_W{1'b0}}});
      rest_addr   = AW'(rest_sum);
      payload_off = OFFW'({pos + PW'(1), {FLAG_W{1'b0}}});
   end

endmodule

`default_nettype wire

// ----- sv/ffha_checker.sv -----
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
`default_nettype none

module ffha_checker import ffha_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   // the header sweep after reset keeps requests out
   a_init_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted right after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   a_fail_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.payload_offset == '0)
      else $error("failed response carries an offset");

   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_OK |-> rsp_payload.payload_offset[2:0] == 3'b000)
      else $error("payload offset not word aligned");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

// ----- verif/tb_first_fit_heap_allocator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_heap_allocator: directed probes, then random traffic.
// Depends on ffha_pkg, ffha_chan_if and the allocator RTL.

module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int HEAP_WORDS      = DEFAULT_HEAP_WORDS;
   localparam int INIT_WORDS      = DEFAULT_INIT_BLOCK_WORDS;
   localparam int N_PROBES        = 23;
   localparam int N_PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int LONG_HOLD       = 400;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type answer;
   } probe_row_type;

   // Rows with typed set carry an answer that is plain from the reset layout.
   probe_row_type probe_rows [N_PROBES] = '{
      '{'{OP_ALLOC,   10'd1023, 10'd0},    1'b1, '{10'd0,    STATUS_NO_FIT}},
      '{'{OP_ALLOC,   10'd72,   10'd1023}, 1'b1, '{10'd8,    STATUS_OK}},
      '{'{OP_ALLOC,   10'd72,   10'd0},    1'b1, '{10'd88,   STATUS_OK}},
      '{'{OP_ALLOC,   10'd72,   10'd0},    1'b1, '{10'd168,  STATUS_OK}},
      '{'{OP_ALLOC,   10'd72,   10'd0},    1'b1, '{10'd248,  STATUS_OK}},
      '{'{OP_ALLOC,   10'd72,   10'd0},    1'b1, '{10'd328,  STATUS_OK}},
      '{'{OP_ALLOC,   10'd608,  10'd0},    1'b1, '{10'd408,  STATUS_OK}},
      // last free word sits at 127: its payload offset is past the field
      '{'{OP_ALLOC,   10'd0,    10'd0},    1'b1, '{10'd0,    STATUS_NO_FIT}},
      '{'{OP_RELEASE, 10'd1023, 10'd1023}, 1'b1, '{10'd0,    STATUS_MISALIGNED}},
      '{'{OP_RELEASE, 10'd0,    10'd0},    1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd1016}, 1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd88},   1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd88},   1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_ALLOC,   10'd0,    10'd0},    1'b1, '{10'd88,   STATUS_OK}},
      '{'{OP_ALLOC,   10'd64,   10'd0},    1'b0, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd408},  1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd12},   1'b1, '{10'd0,    STATUS_MISALIGNED}},
      '{'{OP_ALLOC,   10'd1000, 10'd0},    1'b0, '{10'd0,    STATUS_OK}},
      '{'{OP_ALLOC,   10'd600,  10'd0},    1'b0, '{10'd0,    STATUS_OK}},
      '{'{OP_ALLOC,   10'd1,    10'd0},    1'b0, '{10'd0,    STATUS_OK}},
      '{'{OP_ALLOC,   10'd0,    10'd0},    1'b0, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd1016}, 1'b1, '{10'd0,    STATUS_OK}},
      '{'{OP_RELEASE, 10'd0,    10'd1008}, 1'b0, '{10'd0,    STATUS_OK}}
   };

   bit phase_split [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   logic clock;
   logic reset;

   ffha_chan_if #(.payload_type(req_type)) req_bus ();
   ffha_chan_if #(.payload_type(rsp_type)) rsp_bus ();
   ffha_chan_if #(.payload_type(csr_type)) csr_bus ();

   first_fit_heap_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state
   logic [10:0] heap_hdr [HEAP_WORDS];
   logic        split_mode;
   rsp_type     pending_rsp [$];
   int          live_offsets [$];

   logic        row_typed;
   rsp_type     row_answer;
   logic        burst_mode;
   int          hold_order;

   int errors;
   int n_requests, n_alloc, n_no_fit, n_release, n_misaligned, n_csr;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #16ms;
      $display("tb_first_fit_heap_allocator: done, errors");
      $finish;
   end

   function automatic void init_heap();
      int pos;
      int i;
      pos = 0;
      foreach (heap_hdr[k]) heap_hdr[k] = '0;
      for (i = 0; i < INIT_SMALL_BLOCKS && pos + INIT_WORDS <= HEAP_WORDS; i++) begin
         heap_hdr[pos] = 11'(INIT_WORDS * WORD_BYTES);
         pos += INIT_WORDS;
      end
      if (pos < HEAP_WORDS) heap_hdr[pos] = 11'((HEAP_WORDS - pos) * WORD_BYTES);
   endfunction

   // First-fit walk over the headers, or a taken-flag clear for a release.
   function automatic rsp_type heap_step(req_type it);
      rsp_type res;
      int need, pos, size, word;
      res.payload_offset = '0;
      res.status = STATUS_OK;
      if (it.opcode == OP_ALLOC) begin
         need = (int'(it.request_bytes) + WORD_BYTES - 1) / WORD_BYTES + 1;
         pos = 0;
         res.status = STATUS_NO_FIT;
         while (pos < HEAP_WORDS) begin
            size = int'(heap_hdr[pos]) / WORD_BYTES;
            if (size == 0) break;
            if (heap_hdr[pos][FLAG_W-1:0] == '0 && size >= need
                && (pos + 1) * WORD_BYTES <= PAYLOAD_MAX) begin
               if (split_mode && size > need) begin
                  heap_hdr[pos] = 11'(need * WORD_BYTES) | 11'(TAKEN_FLAGS);
                  heap_hdr[pos + need] = 11'((size - need) * WORD_BYTES);
               end else begin
                  heap_hdr[pos] = heap_hdr[pos] | 11'(TAKEN_FLAGS);
               end
               res.payload_offset = OFFW'((pos + 1) * WORD_BYTES);
               res.status = STATUS_OK;
               return res;
            end
            pos += size;
         end
      end else if (it.release_offset[FLAG_W-1:0] != '0) begin
         res.status = STATUS_MISALIGNED;
      end else if (int'(it.release_offset) >= WORD_BYTES) begin
         word = int'(it.release_offset) / WORD_BYTES - 1;
         if (word < HEAP_WORDS) heap_hdr[word][FLAG_W-1:0] = '0;
      end
      return res;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   // Mostly allocations and releases of live blocks; the rest is stray releases.
   function automatic req_type random_request();
      req_type it;
      int r, k;
      it.request_bytes = OFFW'($urandom_range(0, 1023));
      it.release_offset = OFFW'($urandom_range(0, 1023));
      r = $urandom_range(0, 99);
      if (r < 50) begin
         it.opcode = OP_ALLOC;
         k = $urandom_range(0, 99);
         if (k < 65) it.request_bytes = OFFW'($urandom_range(0, 64));
         else if (k < 90) it.request_bytes = OFFW'($urandom_range(65, 300));
         else it.request_bytes = OFFW'($urandom_range(301, 1023));
      end else if (r < 82 && live_offsets.size() > 0) begin
         it.opcode = OP_RELEASE;
         k = $urandom_range(0, live_offsets.size() - 1);
         it.release_offset = OFFW'(live_offsets[k]);
         live_offsets.delete(k);
      end else begin
         it.opcode = OP_RELEASE;
         if ($urandom_range(0, 2) == 0) it.release_offset[FLAG_W-1:0] = '0;
      end
      return it;
   endfunction

   task automatic idle_before_request();
      int gap;
      gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : random_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
   endtask

   // Called at a falling edge; returns at the edge of the transfer.
   task automatic offer_request(req_type item);
      req_bus.valid <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_split(logic value);
      csr_type w;
      w.split_enable = value;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.payload <= w;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_order != holds_done) begin
            holds_done++;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (burst_mode || $urandom_range(0, 7) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            stall_left = random_gap() - 1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type predicted, want, got;
      if (reset) begin
         init_heap();
         split_mode = 1'b1;
         pending_rsp.delete();
         live_offsets.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            split_mode = csr_bus.payload.split_enable;
            n_csr++;
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = heap_step(req_bus.payload);
            pending_rsp.push_back(row_typed ? row_answer : predicted);
            n_requests++;
            if (req_bus.payload.opcode == OP_ALLOC) begin
               n_alloc++;
               if (predicted.status == STATUS_OK)
                  live_offsets.push_back(int'(predicted.payload_offset));
               else
                  n_no_fit++;
            end else begin
               n_release++;
               if (predicted.status == STATUS_MISALIGNED) n_misaligned++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: response with nothing outstanding, actual offset %0d status %s",
                        $time, got.payload_offset, got.status.name());
            end else begin
               want = pending_rsp.pop_front();
               if (got.payload_offset !== want.payload_offset) begin
                  errors++;
                  $display("%0t: payload_offset mismatch, expected %0d, actual %0d",
                           $time, want.payload_offset, got.payload_offset);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %s, actual %s",
                           $time, want.status.name(), got.status.name());
               end
            end
         end
      end
   end

   initial begin
      int p, i;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      csr_bus.valid = 1'b0;
      csr_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      row_typed = 1'b0;
      row_answer = '0;
      burst_mode = 1'b0;
      hold_order = 0;
      errors = 0;
      n_requests = 0;
      n_alloc = 0;
      n_no_fit = 0;
      n_release = 0;
      n_misaligned = 0;
      n_csr = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // CSR transfers go through during the header sweep
      write_split(1'b1);

      for (i = 0; i < N_PROBES; i++) begin
         idle_before_request();
         row_typed = probe_rows[i].typed;
         row_answer = probe_rows[i].answer;
         offer_request(probe_rows[i].item);
      end

      for (p = 0; p < N_PHASES; p++) begin
         drain_responses();
         write_split(phase_split[p]);
         burst_mode <= (p == 3);
         if (p == 1) hold_order <= hold_order + 1;
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            idle_before_request();
            row_typed = 1'b0;
            offer_request(random_request());
         end
      end

      drain_responses();
      repeat (HEAP_WORDS + 8) @(posedge clock);

      $display("covered %0d requests: %0d allocations (%0d without fit), %0d releases",
               n_requests, n_alloc, n_no_fit, n_release);
      $display("%0d misaligned releases, %0d split_enable writes, one long receiver hold-off",
               n_misaligned, n_csr);
      if (errors == 0) begin
         $display("tb_first_fit_heap_allocator: done, clean");
      end else begin
         $display("tb_first_fit_heap_allocator: done, errors");
      end
      $finish;
   end

endmodule
